// ----- rtl/dpcm_enc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// DPCM step-table encoder package
// Types, register indexes and the fixed step tables for code widths of one to three bits.
// ----------------------------------------------------------------------------
package dpcm_enc_pkg;

  localparam int MAX_CODE_BITS = 8;
  localparam int BYTE_W        = 8;
  localparam int PRED_W        = 16;
  localparam int STEP_W        = 9;
  localparam int PAD_W         = 6;
  localparam int PAD_CAP       = 62;

  // Configuration register indexes.
  localparam logic [1:0] REG_PACKET_SAMPLES = 2'd0;
  localparam logic [1:0] REG_PAYLOAD_BYTES  = 2'd1;
  localparam logic [1:0] REG_BITS_PER_CODE  = 2'd2;

  // Everything one input word produces on the output side.
  typedef struct packed {
    logic               code_v;
    logic [BYTE_W-1:0]  code_byte;
    logic               flush_v;
    logic [BYTE_W-1:0]  flush_byte;
    logic [PAD_W-1:0]   pad_cnt;
    logic               ctrl_v;
    logic [BYTE_W-1:0]  ctrl_byte;
  } job_t;

  // Step tables for code widths of one to three bits.
  function automatic logic signed [STEP_W-1:0] step_small(input logic [1:0] width,
                                                          input logic [2:0] idx);
    logic signed [STEP_W-1:0] val;
    val = '0;
    case (width)
      2'd1: val = idx[0] ? 9'sd1 : -9'sd1;
      2'd2: begin
        case (idx[1:0])
          2'd0:    val = -9'sd8;
          2'd1:    val = -9'sd1;
          2'd2:    val = 9'sd1;
          default: val = 9'sd8;
        endcase
      end
      default: begin
        case (idx)
          3'd0:    val = -9'sd10;
          3'd1:    val = -9'sd6;
          3'd2:    val = -9'sd2;
          3'd3:    val = -9'sd1;
          3'd4:    val = 9'sd0;
          3'd5:    val = 9'sd1;
          3'd6:    val = 9'sd3;
          default: val = 9'sd7;
        endcase
      end
    endcase
    return val;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/dpcm_step_table_encoder.sv -----
`timescale 1ns / 1ps
`default_nettype none
// An input sample's result words are registered in the output sequencer, directly or via the skid register.
// Throughput: one sample per cycle while each sample yields at most one word and the
// output is not stalled; a packet's last sample yields up to 64 words, sent one per cycle
// while out_ready is high; the one-entry skid register takes one more sample's words.
// Reset (synchronous, active low) clears prediction, packet position, packer and
// output queue, and loads the default configuration (64 samples, 32 bytes, 4 bits).
// ----------------------------------------------------------------------------
// DPCM step-table encoder
// Predicts each sample, quantizes the difference with a step table, packs the
// codes MSB first into bytes and closes every packet with padding and a control byte.
// ----------------------------------------------------------------------------
module dpcm_step_table_encoder (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [dpcm_enc_pkg::BYTE_W-1:0]   in_sample,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic [dpcm_enc_pkg::BYTE_W-1:0]        out_byte,
  output logic                                   out_packet_end,
  input  wire logic                              cfg_we,
  input  wire logic [1:0]                        cfg_index,
  input  wire logic [dpcm_enc_pkg::BYTE_W-1:0]   cfg_wdata
);
  import dpcm_enc_pkg::*;

  // Configuration.
  logic [7:0] packet_samples_r;
  logic [7:0] payload_bytes_r;
  logic [3:0] bits_per_code_r;

  // Encoder state.
  logic signed [PRED_W-1:0] pred_r, pred_nxt;
  logic [7:0] start_pred_r, start_pred_nxt;
  logic [7:0] sample_idx_r, sample_idx_nxt;
  logic [7:0] acc_r, acc_nxt;
  logic [3:0] filled_r, filled_nxt;
  logic [7:0] emitted_r, emitted_nxt;

  // Output sequencer.
  job_t cur_r, cur_nxt;
  job_t pend_r, pend_nxt;
  logic pend_v_r, pend_v_nxt;

  logic       in_fire;
  logic       out_fire;
  logic [3:0] width;
  logic [8:0] n_full;
  logic [7:0] n_m1;
  logic [8:0] half;
  logic signed [16:0] delta;
  logic signed [17:0] offset;
  logic signed [STEP_W-1:0] small_entry;
  logic [3:0] small_cnt;
  logic [7:0] code;
  logic signed [STEP_W-1:0] step;
  logic signed [16:0] pred_sum;
  logic [15:0] packed_bits;
  logic [4:0] total;
  logic [3:0] rem;
  logic       full;
  logic [7:0] full_byte;
  logic [7:0] acc_a;
  logic [3:0] filled_a;
  logic       pkt_end;
  logic [7:0] plen;
  logic [7:0] start_pred_eff;
  logic [7:0] emitted_a;
  logic [7:0] emitted_b;
  logic [7:0] pad_raw;
  logic [7:0] pad_cap;
  job_t       new_job;
  logic       new_busy;
  logic       cur_busy;
  logic [6:0] cur_left;
  logic       cur_free;
  job_t       cur_adv;

  assign in_ready = !pend_v_r;
  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid && out_ready;

  // Effective code width, clamped to 1..MAX_CODE_BITS.
  always_comb begin
    if (bits_per_code_r == 4'd0) begin
      width = 4'd1;
    end else if (bits_per_code_r > 4'(MAX_CODE_BITS)) begin
      width = 4'(MAX_CODE_BITS);
    end else begin
      width = bits_per_code_r;
    end
  end

  assign n_full = 9'd1 << width;
  assign n_m1   = 8'(n_full - 9'd1);
  assign half   = 9'd1 << (width - 4'd1);
  assign delta  = $signed({9'd0, in_sample}) - $signed({pred_r[15], pred_r});
  assign offset = $signed({delta[16], delta}) + $signed({9'd0, half});

  // Small tables are sorted, so the code is the number of entries below the difference.
  always_comb begin
    small_cnt   = '0;
    small_entry = '0;
    for (int i = 0; i < 8; i++) begin
      small_entry = step_small(width[1:0], 3'(i));
      if ((9'(i) < n_full) &&
          ($signed({{8{small_entry[STEP_W-1]}}, small_entry}) < delta)) begin
        small_cnt = small_cnt + 4'd1;
      end
    end
  end

  always_comb begin
    if (width <= 4'd3) begin
      if ({5'd0, small_cnt} >= n_full) begin
        code = n_m1;
      end else begin
        code = {4'd0, small_cnt};
      end
      step = step_small(width[1:0], code[2:0]);
    end else begin
      // Linear table: the code is the difference offset by half the table, clamped.
      if (offset < 0) begin
        code = '0;
      end else if (offset > $signed({10'd0, n_m1})) begin
        code = n_m1;
      end else begin
        code = offset[7:0];
      end
      step = $signed({1'b0, code}) - $signed(half);
    end
  end

  assign pred_sum = $signed({pred_r[15], pred_r}) + $signed({{8{step[STEP_W-1]}}, step});

  always_comb begin
    if (pred_sum > 17'sd32767) begin
      pred_nxt = 16'sh7fff;
    end else if (pred_sum < -17'sd32768) begin
      pred_nxt = 16'sh8000;
    end else begin
      pred_nxt = pred_sum[15:0];
    end
  end

  // Bit packer: at most one full byte per sample since a code is at most eight bits.
  assign packed_bits = ({8'd0, acc_r} << width) | {8'd0, code};
  assign total       = {1'b0, filled_r} + {1'b0, width};
  assign full        = total >= 5'd8;
  assign rem         = 4'(total - 5'd8);
  assign full_byte   = 8'(packed_bits >> rem);

  always_comb begin
    if (full) begin
      acc_a    = packed_bits[7:0] & 8'((9'd1 << rem) - 9'd1);
      filled_a = rem;
    end else begin
      acc_a    = packed_bits[7:0];
      filled_a = total[3:0];
    end
  end

  assign plen           = (packet_samples_r == 8'd0) ? 8'd1 : packet_samples_r;
  assign pkt_end        = ({1'b0, sample_idx_r} + 9'd1) >= {1'b0, plen};
  assign start_pred_eff = (sample_idx_r == 8'd0) ? pred_r[7:0] : start_pred_r;

  // Byte counter saturates at 255.
  assign emitted_a = (full && emitted_r != 8'hff) ? emitted_r + 8'd1 : emitted_r;
  assign emitted_b = (filled_a != 4'd0 && emitted_a != 8'hff) ? emitted_a + 8'd1
                                                              : emitted_a;
  assign pad_raw   = (payload_bytes_r > emitted_b) ? payload_bytes_r - emitted_b : 8'd0;
  // With a code byte and a flush byte ahead, the padding may not push the total past 64.
  assign pad_cap   = (full && filled_a != 4'd0) ? 8'(PAD_CAP - 1) : 8'(PAD_CAP);

  always_comb begin
    new_job            = '0;
    new_job.code_v     = full;
    new_job.code_byte  = full_byte;
    new_job.ctrl_byte  = start_pred_eff;
    if (pkt_end) begin
      new_job.flush_v    = filled_a != 4'd0;
      new_job.flush_byte = acc_a << (4'd8 - filled_a);
      new_job.pad_cnt    = (pad_raw > pad_cap) ? PAD_W'(pad_cap) : PAD_W'(pad_raw);
      new_job.ctrl_v     = 1'b1;
    end
  end

  assign new_busy = new_job.code_v || new_job.ctrl_v;

  always_comb begin
    start_pred_nxt = start_pred_r;
    sample_idx_nxt = sample_idx_r;
    acc_nxt        = acc_r;
    filled_nxt     = filled_r;
    emitted_nxt    = emitted_r;
    if (in_fire) begin
      start_pred_nxt = start_pred_eff;
      if (pkt_end) begin
        sample_idx_nxt = '0;
        acc_nxt        = '0;
        filled_nxt     = '0;
        emitted_nxt    = '0;
      end else begin
        sample_idx_nxt = sample_idx_r + 8'd1;
        acc_nxt        = acc_a;
        filled_nxt     = filled_a;
        emitted_nxt    = emitted_a;
      end
    end
  end

  // Output sequencer: code byte, flush byte, padding, then control byte.
  assign cur_left = 7'(cur_r.code_v) + 7'(cur_r.flush_v) + 7'(cur_r.pad_cnt)
                  + 7'(cur_r.ctrl_v);
  assign cur_busy = cur_left != 7'd0;
  assign cur_free = !cur_busy || (out_fire && cur_left == 7'd1);

  assign out_valid      = cur_busy;
  assign out_packet_end = !cur_r.code_v && !cur_r.flush_v && cur_r.pad_cnt == '0;

  always_comb begin
    if (cur_r.code_v) begin
      out_byte = cur_r.code_byte;
    end else if (cur_r.flush_v) begin
      out_byte = cur_r.flush_byte;
    end else if (cur_r.pad_cnt != '0) begin
      out_byte = '0;
    end else begin
      out_byte = cur_r.ctrl_byte;
    end
  end

  always_comb begin
    cur_adv = cur_r;
    if (out_fire) begin
      if (cur_r.code_v) begin
        cur_adv.code_v = 1'b0;
      end else if (cur_r.flush_v) begin
        cur_adv.flush_v = 1'b0;
      end else if (cur_r.pad_cnt != '0) begin
        cur_adv.pad_cnt = cur_r.pad_cnt - PAD_W'(1);
      end else begin
        cur_adv.ctrl_v = 1'b0;
      end
    end
  end

  always_comb begin
    cur_nxt    = cur_adv;
    pend_nxt   = pend_r;
    pend_v_nxt = pend_v_r;
    if (in_fire) begin
      // The skid register is empty whenever a word is taken in.
      if (cur_free) begin
        cur_nxt = new_job;
      end else if (new_busy) begin
        pend_nxt   = new_job;
        pend_v_nxt = 1'b1;
      end
    end else if (cur_free && pend_v_r) begin
      cur_nxt    = pend_r;
      pend_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      packet_samples_r <= 8'd64;
      payload_bytes_r  <= 8'd32;
      bits_per_code_r  <= 4'd4;
      pred_r           <= '0;
      start_pred_r     <= '0;
      sample_idx_r     <= '0;
      acc_r            <= '0;
      filled_r         <= '0;
      emitted_r        <= '0;
      cur_r            <= '0;
      pend_r           <= '0;
      pend_v_r         <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_PACKET_SAMPLES: packet_samples_r <= cfg_wdata;
          REG_PAYLOAD_BYTES:  payload_bytes_r  <= cfg_wdata;
          REG_BITS_PER_CODE:  bits_per_code_r  <= cfg_wdata[3:0];
          default: ;
        endcase
      end
      if (in_fire) begin
        pred_r <= pred_nxt;
      end
      start_pred_r <= start_pred_nxt;
      sample_idx_r <= sample_idx_nxt;
      acc_r        <= acc_nxt;
      filled_r     <= filled_nxt;
      emitted_r    <= emitted_nxt;
      cur_r        <= cur_nxt;
      pend_r       <= pend_nxt;
      pend_v_r     <= pend_v_nxt;
    end
  end

endmodule
`default_nettype wire
